FILE: design/mtb_pkg.sv
// Shared constants, types and request and data structs for the timer bank.
`default_nettype none
package mtb_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int TICK_W     = 16;
  localparam int MODE_W     = 2;
  localparam int OP_W       = 3;
  localparam int TIDX_W     = 5;
  localparam int MASK_W     = 32;

  localparam logic [OP_W-1:0] OP_SCAN  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STARTED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ELAPSED = 2'd3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [MODE_W-1:0] mode_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } mtb_rd_req_t;

  typedef struct packed {
    logic  t_we;
    logic  d_we;
    idx_t  addr;
    mode_t mode;
    tick_t base;
    tick_t dur;
  } mtb_wr_req_t;

  typedef struct packed {
    mode_t mode;
    tick_t base;
    tick_t dur;
  } mtb_rd_data_t;

endpackage
`default_nettype wire

FILE: design/mtb_store.sv
// Timer entry memories: mode/base store with per-entry valid bits, and duration store.
`default_nettype none
module mtb_store (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mtb_pkg::mtb_rd_req_t rd_req,
  input  wire mtb_pkg::mtb_wr_req_t wr_req,
  output mtb_pkg::mtb_rd_data_t     rd_data
);

  logic [mtb_pkg::MODE_W+mtb_pkg::TICK_W-1:0] tmr_mem [mtb_pkg::NUM_TIMERS];
  mtb_pkg::tick_t                             dur_mem [mtb_pkg::NUM_TIMERS];
  logic [mtb_pkg::NUM_TIMERS-1:0]             vld;

  logic [mtb_pkg::MODE_W+mtb_pkg::TICK_W-1:0] tmr_q;
  mtb_pkg::tick_t                             dur_q;
  logic                                       vld_q;

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      tmr_q <= tmr_mem[rd_req.addr];
      dur_q <= dur_mem[rd_req.addr];
      vld_q <= vld[rd_req.addr];
    end
    if (wr_req.t_we) begin
      tmr_mem[wr_req.addr] <= {wr_req.mode, wr_req.base};
    end
    if (wr_req.d_we) begin
      dur_mem[wr_req.addr] <= wr_req.dur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_req.t_we) begin
      vld[wr_req.addr] <= 1'b1;
    end
  end

  // never-written entries read as stopped with a zero base
  assign rd_data.mode = vld_q ? tmr_q[mtb_pkg::MODE_W+mtb_pkg::TICK_W-1:mtb_pkg::TICK_W]
                              : mtb_pkg::MODE_STOPPED;
  assign rd_data.base = vld_q ? tmr_q[mtb_pkg::TICK_W-1:0] : '0;
  assign rd_data.dur  = dur_q;

endmodule
`default_nettype wire

FILE: design/multi_timer_bank.sv
// Top level of the timer bank: command sequencer, scan pipeline and elapsed flags.
//
// Each command is taken when start is high and busy is low, and yields exactly one
// result, shown for one cycle with done high; the receiver cannot stall it.
// Start, stop and read go through S_RD (one read of the timer memory) and S_MOD
// (the write-back, for start and stop only); load, reserved and out-of-range
// commands go straight to S_FIN. A scan walks the timer memory one entry per
// cycle, reading entry i while writing back entry i-1. busy drops in
// the cycle done is high, so the next command can follow at once. elapsed_mask
// reflects every timer's elapsed state after the command.
`default_nettype none
module multi_timer_bank (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [4:0]  timer_index,
  input  wire logic [15:0] time_now,
  input  wire logic [15:0] duration_value,
  output logic             done,
  output logic [15:0]      elapsed_ticks,
  output logic [1:0]       timer_state,
  output logic [31:0]      elapsed_mask
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                    state;
  logic [mtb_pkg::OP_W-1:0]      op_q;
  mtb_pkg::idx_t                 idx_q;
  logic                          ok_q;
  mtb_pkg::tick_t                now_q;
  mtb_pkg::tick_t                dur_q;
  logic [mtb_pkg::CNT_W-1:0]     cnt;
  logic                          pv;
  mtb_pkg::idx_t                 pidx;
  logic [mtb_pkg::NUM_TIMERS-1:0] flags;

  mtb_pkg::mtb_rd_req_t  rd_req;
  mtb_pkg::mtb_wr_req_t  wr_req;
  mtb_pkg::mtb_rd_data_t rd_data;

  logic           accept;
  logic           in_ok;
  logic           cnt_live;
  mtb_pkg::tick_t gone;
  logic           expired;

  mtb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (rd_data)
  );

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign in_ok    = (32'(timer_index) < 32'(mtb_pkg::NUM_TIMERS));
  assign cnt_live = (cnt < mtb_pkg::CNT_W'(mtb_pkg::NUM_TIMERS));
  assign gone     = now_q - rd_data.base;
  assign expired  = (gone >= rd_data.dur);

  assign elapsed_mask = mtb_pkg::MASK_W'(flags);

  always_comb begin
    rd_req = '0;
    wr_req = '0;
    unique case (state)
      S_RD: begin
        rd_req.en   = 1'b1;
        rd_req.addr = idx_q;
      end
      S_MOD: begin
        wr_req.addr = idx_q;
        wr_req.base = rd_data.base;
        if (op_q == mtb_pkg::OP_START) begin
          wr_req.t_we = 1'b1;
          wr_req.mode = mtb_pkg::MODE_STARTED;
        end else if (op_q == mtb_pkg::OP_STOP) begin
          wr_req.t_we = 1'b1;
          wr_req.mode = mtb_pkg::MODE_STOPPED;
        end
      end
      S_SCAN: begin
        rd_req.en   = cnt_live;
        rd_req.addr = cnt[mtb_pkg::IDX_W-1:0];
        wr_req.addr = pidx;
        if (pv && rd_data.mode == mtb_pkg::MODE_RUNNING && expired) begin
          wr_req.t_we = 1'b1;
          wr_req.mode = mtb_pkg::MODE_ELAPSED;
          wr_req.base = rd_data.base;
        end else if (pv && rd_data.mode == mtb_pkg::MODE_STARTED) begin
          wr_req.t_we = 1'b1;
          wr_req.mode = mtb_pkg::MODE_RUNNING;
          wr_req.base = now_q;
        end
      end
      S_FIN: begin
        wr_req.addr = idx_q;
        wr_req.dur  = dur_q;
        wr_req.d_we = (op_q == mtb_pkg::OP_LOAD) && ok_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      flags <= '0;
      pv    <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= operation;
            idx_q <= mtb_pkg::IDX_W'(timer_index);
            ok_q  <= in_ok;
            now_q <= time_now;
            dur_q <= duration_value;
            cnt   <= '0;
            pv    <= 1'b0;
            if (operation == mtb_pkg::OP_SCAN) begin
              state <= S_SCAN;
            end else if (in_ok && (operation == mtb_pkg::OP_START ||
                                   operation == mtb_pkg::OP_STOP ||
                                   operation == mtb_pkg::OP_READ)) begin
              state <= S_RD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_RD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (op_q == mtb_pkg::OP_READ) begin
            elapsed_ticks <= gone;
            timer_state   <= rd_data.mode;
          end else begin
            flags[idx_q] <= 1'b0;
          end
          state <= S_FIN;
        end
        S_SCAN: begin
          if (cnt_live) begin
            cnt <= cnt + 1'b1;
          end
          pv   <= cnt_live;
          pidx <= cnt[mtb_pkg::IDX_W-1:0];
          if (pv && rd_data.mode == mtb_pkg::MODE_RUNNING && expired) begin
            flags[pidx] <= 1'b1;
          end
          if (!pv && !cnt_live) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done <= 1'b1;
          if (!(op_q == mtb_pkg::OP_READ && ok_q)) begin
            elapsed_ticks <= '0;
            timer_state   <= '0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("done outside idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("transfer did not raise busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (rd_req.en && wr_req.t_we) |-> (rd_req.addr != wr_req.addr))
    else $error("read and write-back hit the same entry");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/multi_timer_bank_tb.sv
// Self-checking testbench for the timer bank: directed and random commands, scoreboard check.
`default_nettype none
module multi_timer_bank_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtb_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 2 * (NUM_TIMERS + 3);

  typedef struct {
    tick_t                   ticks;
    mode_t                   state;
    logic [MASK_W-1:0]       mask;
  } timer_result_t;

  class TimerBankScoreboard;
    mode_t         mode_q [NUM_TIMERS];
    tick_t         base_q [NUM_TIMERS];
    tick_t         dur_q  [NUM_TIMERS];
    bit            loaded [NUM_TIMERS];
    timer_result_t pending[$];
    int            errors;
    int            checked;
    int            op_count [8];
    int            mask_hits;
    int            elapsed_reads;

    function new();
      for (int i = 0; i < NUM_TIMERS; i++) begin
        mode_q[i] = MODE_STOPPED;
        base_q[i] = '0;
        dur_q[i]  = '0;
        loaded[i] = 1'b0;
      end
      errors = 0;
      checked = 0;
      mask_hits = 0;
      elapsed_reads = 0;
      for (int i = 0; i < 8; i++) op_count[i] = 0;
    endfunction

    function void note_transfer(logic [OP_W-1:0] op, logic [TIDX_W-1:0] idx,
                                tick_t now, tick_t dur);
      timer_result_t r;
      bit            addr_ok;
      addr_ok = (int'(idx) < NUM_TIMERS);
      r.ticks = '0;
      r.state = MODE_STOPPED;
      r.mask  = '0;
      op_count[op]++;
      case (op)
        OP_SCAN: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (mode_q[i] == MODE_RUNNING && tick_t'(now - base_q[i]) >= dur_q[i])
              mode_q[i] = MODE_ELAPSED;
            if (mode_q[i] == MODE_STARTED) begin
              base_q[i] = now;
              mode_q[i] = MODE_RUNNING;
            end
          end
        end
        OP_START: if (addr_ok) mode_q[idx] = MODE_STARTED;
        OP_STOP:  if (addr_ok) mode_q[idx] = MODE_STOPPED;
        OP_READ: begin
          if (addr_ok) begin
            r.ticks = tick_t'(now - base_q[idx]);
            r.state = mode_q[idx];
            if (mode_q[idx] == MODE_ELAPSED) elapsed_reads++;
          end
        end
        OP_LOAD: begin
          if (addr_ok) begin
            dur_q[idx]  = dur;
            loaded[idx] = 1'b1;
          end
        end
        default: ;
      endcase
      for (int i = 0; i < NUM_TIMERS && i < MASK_W; i++)
        if (mode_q[i] == MODE_ELAPSED) r.mask[i] = 1'b1;
      if (r.mask != '0) mask_hits++;
      pending.push_back(r);
    endfunction

    function void check_result(tick_t ticks, mode_t state, logic [MASK_W-1:0] mask);
      timer_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result ticks=%h state=%0d mask=%h",
                 $time, ticks, state, mask);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (ticks !== e.ticks) begin
        $display("%0t: elapsed_ticks expected %h actual %h", $time, e.ticks, ticks);
        errors++;
      end
      if (state !== e.state) begin
        $display("%0t: timer_state expected %0d actual %0d", $time, e.state, state);
        errors++;
      end
      if (mask !== e.mask) begin
        $display("%0t: elapsed_mask expected %h actual %h", $time, e.mask, mask);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      operation;
  logic [TIDX_W-1:0]    timer_index;
  tick_t                time_now;
  tick_t                duration_value;
  logic                 done;
  tick_t                elapsed_ticks;
  mode_t                timer_state;
  logic [MASK_W-1:0]    elapsed_mask;

  TimerBankScoreboard sb;
  tick_t              tb_now;

  multi_timer_bank uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .timer_index    (timer_index),
    .time_now       (time_now),
    .duration_value (duration_value),
    .done           (done),
    .elapsed_ticks  (elapsed_ticks),
    .timer_state    (timer_state),
    .elapsed_mask   (elapsed_mask)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TIDX_W-1:0] idx,
                          input tick_t now, input tick_t dur, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    operation      <= op;
    timer_index    <= idx;
    time_now       <= now;
    duration_value <= dur;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transfer(op, idx, now, dur);
  endtask

  task automatic send_random(input int item_no);
    logic [OP_W-1:0]   op;
    logic [TIDX_W-1:0] idx;
    tick_t             dur;
    int                pick;
    int                gap;
    pick = $urandom_range(0, 99);
    if (pick < 25)      op = OP_SCAN;
    else if (pick < 45) op = OP_START;
    else if (pick < 55) op = OP_STOP;
    else if (pick < 80) op = OP_READ;
    else if (pick < 95) op = OP_LOAD;
    else                op = OP_RSVD5 + 3'($urandom_range(0, 2));
    idx = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    // a timer may only run once its duration is loaded
    if (op == OP_START && !sb.loaded[idx]) op = OP_LOAD;
    pick = $urandom_range(0, 7);
    if (op != OP_LOAD)  dur = tick_t'($urandom);
    else if (pick == 0) dur = '0;
    else if (pick == 1) dur = tick_t'($urandom);
    else                dur = tick_t'($urandom_range(1, 100));
    if ($urandom_range(0, 19) == 0) tb_now = tick_t'($urandom);
    else                            tb_now = tb_now + tick_t'($urandom_range(0, 12));
    gap = ((item_no % 256) < 48) ? 0 : $urandom_range(0, 4);
    send_cmd(op, idx, tb_now, dur, gap);
  endtask

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(elapsed_ticks, timer_state, elapsed_mask);
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) idle = 0;
      else idle++;
    end
    $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("multi_timer_bank verification failed");
    $finish;
  end

  initial begin
    sb = new();
    tb_now = 16'd200;
    rst            <= 1'b1;
    start          <= 1'b0;
    operation      <= OP_SCAN;
    timer_index    <= '0;
    time_now       <= '0;
    duration_value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: duration extremes, elapse boundaries, wrap-around, restart, stop, spare codes
    send_cmd(OP_LOAD,  5'd0,  16'd0,     16'd0,     0);
    send_cmd(OP_LOAD,  5'd31, 16'hFFFF,  16'hFFFF,  1);
    send_cmd(OP_LOAD,  5'd5,  16'd0,     16'd10,    0);
    send_cmd(OP_LOAD,  5'd1,  16'd0,     16'd1,     2);
    send_cmd(OP_START, 5'd0,  16'd0,     16'h5555,  0);
    send_cmd(OP_START, 5'd31, 16'd0,     16'hAAAA,  0);
    send_cmd(OP_START, 5'd5,  16'd0,     16'd0,     3);
    send_cmd(OP_START, 5'd1,  16'd0,     16'd0,     0);
    send_cmd(OP_READ,  5'd5,  16'd0,     16'd0,     0);
    send_cmd(OP_SCAN,  5'd0,  16'd100,   16'd0,     0);
    send_cmd(OP_READ,  5'd0,  16'hFFFF,  16'd0,     4);
    send_cmd(OP_SCAN,  5'd0,  16'd100,   16'd0,     0);
    send_cmd(OP_SCAN,  5'd0,  16'd101,   16'd0,     0);
    send_cmd(OP_SCAN,  5'd0,  16'd109,   16'd0,     1);
    send_cmd(OP_SCAN,  5'd0,  16'd110,   16'd0,     0);
    send_cmd(OP_READ,  5'd31, 16'd50,    16'd0,     0);
    send_cmd(OP_SCAN,  5'd0,  16'd98,    16'd0,     0);
    send_cmd(OP_SCAN,  5'd0,  16'd99,    16'd0,     0);
    send_cmd(OP_STOP,  5'd0,  16'd120,   16'd0,     0);
    send_cmd(OP_READ,  5'd0,  16'd120,   16'd0,     2);
    send_cmd(OP_START, 5'd5,  16'd130,   16'd0,     0);
    send_cmd(OP_READ,  5'd17, 16'd130,   16'd0,     0);
    send_cmd(OP_RSVD5, 5'd1,  16'd130,   16'hFFFF,  0);
    send_cmd(OP_RSVD6, 5'd31, 16'd130,   16'd0,     1);
    send_cmd(OP_RSVD7, 5'd0,  16'd130,   16'd0,     0);

    for (int n = 0; n < RANDOM_ITEMS; n++) send_random(n);
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d results: %0d scans, %0d starts, %0d stops, %0d reads, %0d loads",
             sb.checked, sb.op_count[OP_SCAN], sb.op_count[OP_START],
             sb.op_count[OP_STOP], sb.op_count[OP_READ], sb.op_count[OP_LOAD]);
    $display("%0d results with elapsed timers, %0d reads of elapsed timers, %0d errors",
             sb.mask_hits, sb.elapsed_reads, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("multi_timer_bank verification clean");
    end else begin
      $display("multi_timer_bank verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: multi_timer_bank.f
design/mtb_pkg.sv
design/mtb_store.sv
design/multi_timer_bank.sv
tb/sv/multi_timer_bank_tb.sv
